@@ hdl/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared types, constants and round functions for the hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds     = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_INIT,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   // Which bytes the datapath writes into the block buffer.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_BYTE,
      WR_PAD,
      WR_LEN
   } wr_mode_type;

   typedef struct packed {
      wr_mode_type wr_mode;
      logic        accept_byte;
      logic        rd_addr_clr;
      logic        rd_addr_inc;
      logic        init_vars;
      logic        do_round;
      logic        add_chain;
      logic        reset_msg;
      logic        out_valid_set;
   } cmd_type;

   typedef struct packed {
      logic       block_full;
      logic       pad_two;
      logic       load_done;
      logic       round_done;
      logic       out_taken_last;
      logic       ptr_at_55;
      logic       ptr_at_63;
   } sts_type;

   localparam logic [31:0] RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte   = 8'h80;
   localparam logic [5:0] LenOffset = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ hdl/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_ready  | data_byte, byte_present, end
//   rsp_     | out       | rsp_valid/rsp_ready  | digest_word, word_index, last
//
// A byte that does not finish a block is written to the buffer and req_ready
// stays high. The 64th byte of a block starts the buffer read, the setup
// state, 64 rounds and the chain add, all with req_ready low. An end request
// writes the padding and length one byte per cycle, runs one or two blocks
// through the same sequence and then delivers the eight digest words.
// Reset is synchronous and loads the initial hash.
// A stalled rsp_ready holds the current digest word; no request is taken
// until the whole digest has been delivered.
module sha256_byte_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller owns the state sequencing; the datapath follows its commands and steps the digest output itself.
   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

@@ hdl/sha_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module sha_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hdl/sha_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, message schedule, round unit, chaining words and output.
// ----------------------------------------------------------------------------
module sha_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::req_type req_data,
   input  sha_pkg::cmd_type cmd,
   output sha_pkg::sts_type sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   logic [60:0] count_ff, count_in;
   logic [5:0]  wr_ptr_ff, wr_ptr_in;     // padding/length write pointer
   logic [5:0]  rd_ptr_ff;
   logic [6:0]  load_cnt_ff;               // bytes requested from RAM
   logic [6:0]  round_ff;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_ff [8];
   logic [2:0]  out_idx_ff;
   logic        out_valid_ff;
   logic        ram_we;
   logic [5:0]  ram_waddr;
   logic [7:0]  ram_wdata;
   logic [7:0]  ram_rdata;
   logic        load_valid_ff;
   logic [1:0]  byte_pos_ff;
   logic [31:0] word_acc_ff;
   logic [63:0] bits;
   logic [7:0]  len_byte;
   logic [31:0] w_new, w_cur, s0, s1, t1, t2, e_s1, a_s0;

   assign bits = {count_ff, 3'b000};
   // Buffer offsets 56..63 carry the bit length, most significant byte first.
   assign len_byte = bits[{~wr_ptr_ff[2:0], 3'b000} +: 8];

   // Buffer writes. While bytes stream in, the write pointer follows the fill
   // level, so padding starts at the first free offset.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = wr_ptr_ff;
      ram_wdata = 8'h00;
      wr_ptr_in = wr_ptr_ff;
      unique case (cmd.wr_mode)
         WR_BYTE: begin
            ram_we    = cmd.accept_byte;
            ram_waddr = count_ff[5:0];
            ram_wdata = req_data.data_byte;
            wr_ptr_in = count_ff[5:0] + {5'd0, cmd.accept_byte};
         end
         WR_PAD: begin
            ram_we    = 1'b1;
            ram_wdata = (wr_ptr_ff == count_ff[5:0]) ? PadByte : 8'h00;
            wr_ptr_in = wr_ptr_ff + 6'd1;
         end
         WR_LEN: begin
            ram_we    = 1'b1;
            ram_wdata = (wr_ptr_ff >= LenOffset) ? len_byte : 8'h00;
            wr_ptr_in = wr_ptr_ff + 6'd1;
         end
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.reset_msg) begin
         count_in = '0;
      end else if (cmd.accept_byte) begin
         count_in = count_ff + 61'd1;
      end
   end

   sha_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Schedule and round logic.
   assign w_cur = w_ff[0];
   assign s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_new = w_ff[0] + s0 + w_ff[9] + s1;
   assign e_s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
   assign a_s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
   assign t1 = v_ff[7] + e_s1 + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[round_ff[5:0]] + w_cur;
   assign t2 = a_s0 + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         load_cnt_ff   <= '0;
         load_valid_ff <= 1'b0;
         byte_pos_ff   <= '0;
         round_ff      <= '0;
         out_valid_ff  <= 1'b0;
         out_idx_ff    <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= InitHash[i];
         end
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         // Byte stream out of the buffer, packed into schedule words.
         load_valid_ff <= 1'b0;
         if (cmd.rd_addr_clr) begin
            rd_ptr_ff   <= '0;
            load_cnt_ff <= '0;
            byte_pos_ff <= '0;
         end else if (cmd.rd_addr_inc && load_cnt_ff < 7'd64) begin
            rd_ptr_ff     <= rd_ptr_ff + 6'd1;
            load_cnt_ff   <= load_cnt_ff + 7'd1;
            load_valid_ff <= 1'b1;
         end
         if (load_valid_ff) begin
            word_acc_ff <= {word_acc_ff[23:0], ram_rdata};
            byte_pos_ff <= byte_pos_ff + 2'd1;
            if (byte_pos_ff == 2'd3) begin
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i + 1];
               end
               w_ff[15] <= {word_acc_ff[23:0], ram_rdata};
            end
         end
         if (cmd.init_vars) begin
            round_ff <= '0;
            for (int i = 0; i < 8; i++) begin
               v_ff[i] <= h_ff[i];
            end
         end
         if (cmd.do_round) begin
            round_ff <= round_ff + 7'd1;
            v_ff[7] <= v_ff[6];
            v_ff[6] <= v_ff[5];
            v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2];
            v_ff[2] <= v_ff[1];
            v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i + 1];
            end
            w_ff[15] <= w_new;
         end
         if (cmd.add_chain) begin
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
         end
         if (cmd.out_valid_set) begin
            out_valid_ff <= 1'b1;
            out_idx_ff   <= '0;
         end else if (out_valid_ff && rsp_ready) begin
            out_idx_ff <= out_idx_ff + 3'd1;
            if (out_idx_ff == 3'd7) begin
               out_valid_ff <= 1'b0;
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= InitHash[i];
               end
            end
         end
      end
   end

   assign sts.block_full     = (count_ff[5:0] == 6'd63);
   assign sts.pad_two        = (count_ff[5:0] >= LenOffset);
   assign sts.load_done      = (load_cnt_ff == 7'd64) && !load_valid_ff;
   assign sts.round_done     = (round_ff == 7'd63);
   assign sts.out_taken_last = out_valid_ff && rsp_ready && (out_idx_ff == 3'd7);
   assign sts.ptr_at_55      = (wr_ptr_ff == LenOffset - 6'd1);
   assign sts.ptr_at_63      = (wr_ptr_ff == 6'd63);

   assign rsp_valid            = out_valid_ff;
   assign rsp_data.digest_word = h_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == 3'd7);

   assert property (@(posedge clock) disable iff (reset)
      cmd.do_round |-> !cmd.add_chain)
      else $error("round and chain add at once");
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept_byte |-> !out_valid_ff)
      else $error("byte taken while digest pending");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_valid_set |-> !out_valid_ff)
      else $error("digest started twice");
endmodule

@@ hdl/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, block load, rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   input  sha_pkg::sts_type sts,
   output sha_pkg::cmd_type cmd
);
   import sha_pkg::*;

   state_type state_ff, state_in;
   logic      final_ff, final_in;   // finishing the message
   logic      lenblk_ff, lenblk_in; // current block carries the length

   logic take;
   assign take = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      final_in  = final_ff;
      lenblk_in = lenblk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_data.byte_present && sts.block_full) begin
                  state_in = ST_LOAD;
                  final_in = req_data.end_of_message;
                  lenblk_in = 1'b0;
               end else if (req_data.end_of_message) begin
                  state_in  = ST_PAD;
                  final_in  = 1'b1;
               end
            end
         end
         ST_PAD: begin
            // Pad byte and zeros run to the end of the block when the length
            // no longer fits, otherwise up to the start of the length field.
            if (sts.pad_two) begin
               if (sts.ptr_at_63) begin
                  state_in  = ST_LOAD;
                  lenblk_in = 1'b0;
               end
            end else if (sts.ptr_at_55) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (sts.ptr_at_63) begin
               state_in  = ST_LOAD;
               lenblk_in = 1'b1;
            end
         end
         ST_LOAD: begin
            if (sts.load_done) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT:  state_in = ST_ROUND;
         ST_ROUND: if (sts.round_done) state_in = ST_ADD;
         ST_ADD: begin
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (lenblk_ff) begin
               state_in = ST_OUT;
            end else if (sts.pad_two) begin
               state_in = ST_LEN;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: if (sts.out_taken_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.wr_mode = WR_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.wr_mode     = WR_BYTE;
            cmd.accept_byte = take && req_data.byte_present;
            cmd.rd_addr_clr = 1'b1;
         end
         ST_PAD: begin
            cmd.wr_mode     = WR_PAD;
            cmd.rd_addr_clr = 1'b1;
         end
         ST_LEN: begin
            cmd.wr_mode     = WR_LEN;
            cmd.rd_addr_clr = 1'b1;
         end
         ST_LOAD:  cmd.rd_addr_inc = 1'b1;
         ST_INIT:  cmd.init_vars = 1'b1;
         ST_ROUND: cmd.do_round = 1'b1;
         ST_ADD: begin
            cmd.add_chain     = 1'b1;
            cmd.rd_addr_clr   = 1'b1;
            cmd.out_valid_set = final_ff && lenblk_ff;
            cmd.reset_msg     = 1'b0;
         end
         ST_OUT: cmd.reset_msg = sts.out_taken_last;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         final_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         final_ff  <= final_in;
         lenblk_ff <= lenblk_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_valid_set |=> state_ff == ST_OUT)
      else $error("digest without output state");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && sts.round_done) |=> state_ff == ST_ADD)
      else $error("rounds did not end in chain add");
endmodule

@@ sim/sha256_digest_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, computes the expected digest words from the accepted
// requests and compares every response field against them in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sha_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_words
);

   import sha_pkg::*;

   logic [31:0] chain [8];
   logic [7:0]  block [64];
   logic [60:0] byte_count;
   rsp_type     digest_queue [$];

   localparam logic [31:0] Kc [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] Hinit [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int t = 16; t < 64; t++)
         w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
              + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + Kc[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i-1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   // Absorbs one request and queues eight digest words on an end request.
   task automatic absorb_request(input req_type r);
      int          fill;
      logic [63:0] bit_len;
      rsp_type     word;
      if (r.byte_present) begin
         fill = byte_count[5:0];
         block[fill] = r.data_byte;
         byte_count++;
         if (fill == 63) compress_block();
      end
      if (r.end_of_message) begin
         fill = byte_count[5:0];
         block[fill] = 8'h80;
         for (int i = fill + 1; i < 64; i++) block[i] = 8'h00;
         if (fill >= 56) begin
            compress_block();
            for (int i = 0; i < 56; i++) block[i] = 8'h00;
         end
         bit_len = {byte_count, 3'b000};
         for (int i = 0; i < 8; i++) block[63-i] = bit_len[8*i +: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_queue.insert(digest_queue.size(), word);
         end
         for (int i = 0; i < 8; i++) chain[i] = Hinit[i];
         byte_count = '0;
      end
   endtask

   assign pending_words = digest_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 8; i++) chain[i] = Hinit[i];
         byte_count = '0;
         digest_queue.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected digest word %h", rsp_data.digest_word);
               error_count++;
            end else begin
               want = digest_queue.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word expected %h actual %h",
                         want.digest_word, rsp_data.digest_word);
                  error_count++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index expected %0d actual %0d",
                         want.word_index, rsp_data.word_index);
                  error_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word expected %0d actual %0d",
                         want.last_word, rsp_data.last_word);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) absorb_request(req_data);
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives directed and random byte-stream messages into the hasher with random
// idle cycles on both sides, and lets the checker compare every digest word.
// ----------------------------------------------------------------------------
module tb_top;

   import sha_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_words;
   int      cycle_count = 0;
   bit      calm_mode = 1'b0;    // suppresses random idling on both sides
   int      hold_off = 0;        // receiver stall length requested by stimulus

   localparam int CycleLimit = 400000;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sha256_byte_stream_hasher dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   sha256_digest_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .error_count(error_count), .pending_words(pending_words)
   );

   // A watchdog on the cycle count ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[sha256_byte_stream_hasher] ERROR");
         $finish;
      end
   end

   // The receiver stalls at random about a third of the time, except in calm
   // stretches. A requested hold-off keeps ready low for the requested stall length.
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            n = hold_off;
            hold_off = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= calm_mode || ($urandom_range(99) >= 34);
      end
   end

   // Presents one request at the falling edge and holds it until accepted.
   // Valid is left high on return; the next call or wait_drained drives it again at
   // the same falling edge, so it is driven only once per edge.
   task automatic send_request(input logic [7:0] b, input logic p, input logic e);
      while (!calm_mode && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, byte_present: p, end_of_message: e};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Sends a message of random bytes; the end flag rides on the last byte or
   // on a separate finish-only request. Stray empty requests are mixed in.
   task automatic send_message(input int length, input bit end_alone);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1,
                      (!end_alone && i == length - 1) ? 1'b1 : 1'b0);
      end
      if (end_alone || length == 0) send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty message, extreme bytes, a request with neither flag.
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'h5a, 1'b0, 1'b0);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'haa, 1'b1, 1'b0);
      send_request(8'h55, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      wait_drained();

      // The sender keeps offering while the receiver holds off for a long
      // stretch, so the undelivered digest stalls its input.
      hold_off = 300;
      send_message(2, 1'b0);
      send_message(3, 1'b1);
      wait_drained();

      // A stretch with no idling on either side. Sixty bytes leave no room
      // for the length, so the padding needs a second block.
      calm_mode = 1'b1;
      send_message(60, 1'b1);
      wait_drained();
      calm_mode = 1'b0;

      // Random short messages.
      for (int m = 0; m < 4; m++) begin
         send_message($urandom_range(12), $urandom_range(1));
      end

      wait_drained();
      repeat (50) @(negedge clock);
      if (error_count == 0) begin
         $display("[sha256_byte_stream_hasher] OK");
      end else begin
         $display("[sha256_byte_stream_hasher] ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/sha_pkg.sv
hdl/sha_ram.sv
hdl/sha_datapath.sv
hdl/sha_ctrl.sv
hdl/sha256_byte_stream_hasher.sv
sim/sha256_digest_checker.sv
sim/tb_top.sv
